>>> design/sfe_pkg.sv
`default_nettype none

package sfe_pkg;

   localparam logic [7:0] FLAG_BYTE     = 8'h7E;
   localparam logic [7:0] ESC_BYTE      = 8'h7D;
   localparam logic [7:0] ESC_MASK      = 8'h20;
   localparam logic [7:0] PROTO_BYTE    = 8'h45;
   localparam logic [7:0] DISPATCH_BYTE = 8'h00;
   localparam logic [7:0] NEWLINE_BYTE  = 8'h0A;

   // header byte order after the opening flag
   localparam int HDR_COUNT = 9;
   localparam logic [3:0] HDR_PROTO    = 4'd0;
   localparam logic [3:0] HDR_DISPATCH = 4'd1;
   localparam logic [3:0] HDR_DEST_HI  = 4'd2;
   localparam logic [3:0] HDR_DEST_LO  = 4'd3;
   localparam logic [3:0] HDR_SRC_HI   = 4'd4;
   localparam logic [3:0] HDR_SRC_LO   = 4'd5;
   localparam logic [3:0] HDR_LENGTH   = 4'd6;
   localparam logic [3:0] HDR_GROUP    = 4'd7;
   localparam logic [3:0] HDR_TYPE     = 4'd8;

   // control register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MSG_TYPE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_ID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADDR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ADDR  = 3'd3;

   typedef struct packed {
      logic [7:0]  msg_type;
      logic [7:0]  group_id;
      logic [15:0] dest_addr;
      logic [15:0] src_addr;
   } hdr_cfg_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c = c ^ {8'h00, b};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {3'b000, c[7:0], 5'b00000};
      return c;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input hdr_cfg_type cfg,
                                           input logic [7:0] len_byte);
      logic [7:0] r;
      unique case (idx)
         HDR_PROTO:    r = PROTO_BYTE;
         HDR_DISPATCH: r = DISPATCH_BYTE;
         HDR_DEST_HI:  r = cfg.dest_addr[15:8];
         HDR_DEST_LO:  r = cfg.dest_addr[7:0];
         HDR_SRC_HI:   r = cfg.src_addr[15:8];
         HDR_SRC_LO:   r = cfg.src_addr[7:0];
         HDR_LENGTH:   r = len_byte;
         HDR_GROUP:    r = cfg.group_id;
         HDR_TYPE:     r = cfg.msg_type;
         default:      r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/sfe_store.sv
`default_nettype none

module sfe_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/sfe_frame.sv
`default_nettype none

module sfe_frame
   import sfe_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 16,
   parameter int CNT_W         = 5,
   parameter int IDX_W         = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CNT_W-1:0] start_len,
   input  wire hdr_cfg_type      hdr_cfg,
   output logic                  busy,
   output logic                  mem_rd_en,
   output logic      [IDX_W-1:0] mem_rd_addr,
   input  wire logic [7:0]       mem_rd_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [7:0]       rsp_line_byte,
   output logic                  rsp_frame_end
);

   localparam int POS_W     = $clog2(PAYLOAD_BYTES + 13);
   localparam int PAY_FIRST = 1 + HDR_COUNT;
   localparam int PAY_LAST  = PAY_FIRST + PAYLOAD_BYTES - 1;
   localparam int CRC_LO    = PAY_LAST + 1;
   localparam int CRC_HI    = PAY_LAST + 2;
   localparam int LAST_POS  = PAY_LAST + 3;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_ESC   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [15:0]      crc_ff, crc_in;
   logic             pad_ff, pad_in;
   logic [7:0]       esc_ff, esc_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_end_ff, out_end_in;

   logic [POS_W-1:0] pay_idx;
   logic             in_hdr, in_pay, in_crc, is_last;
   logic [7:0]       raw;
   logic             need_esc;
   logic             out_free;

   assign pay_idx = pos_ff - POS_W'(PAY_FIRST);
   assign in_hdr  = (pos_ff >= POS_W'(1)) && (pos_ff < POS_W'(PAY_FIRST));
   assign in_pay  = (pos_ff >= POS_W'(PAY_FIRST)) && (pos_ff <= POS_W'(PAY_LAST));
   assign in_crc  = (pos_ff == POS_W'(CRC_LO)) || (pos_ff == POS_W'(CRC_HI));
   assign is_last = (pos_ff == POS_W'(LAST_POS));
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      if (in_hdr) begin
         raw = hdr_byte(4'(pos_ff - POS_W'(1)), hdr_cfg, 8'(PAYLOAD_BYTES));
      end else if (in_pay) begin
         raw = pad_ff ? 8'h00 : mem_rd_data;
      end else if (pos_ff == POS_W'(CRC_LO)) begin
         raw = crc_ff[7:0];
      end else if (pos_ff == POS_W'(CRC_HI)) begin
         raw = crc_ff[15:8];
      end else begin
         raw = FLAG_BYTE;
      end
   end

   assign need_esc = (in_hdr || in_pay || in_crc) && ((raw == FLAG_BYTE) || (raw == ESC_BYTE));

   assign mem_rd_en   = (state_ff == ST_FETCH) && in_pay && (pay_idx < POS_W'(len_ff));
   assign mem_rd_addr = pay_idx[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      pad_in       = pad_ff;
      esc_in       = esc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FETCH;
               pos_in   = '0;
               len_in   = start_len;
               crc_in   = '0;
            end
         end
         ST_FETCH: begin
            // store data is registered and used in the EMIT state that follows; pad bytes skip the read
            pad_in   = !mem_rd_en;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_end_in   = is_last;
               if (in_hdr || in_pay) begin
                  crc_in = crc_update(crc_ff, raw);
               end
               if (need_esc) begin
                  out_byte_in = ESC_BYTE;
                  esc_in      = raw ^ ESC_MASK;
                  state_in    = ST_ESC;
               end else begin
                  out_byte_in = raw;
                  if (is_last) begin
                     state_in = ST_IDLE;
                     crc_in   = '0;
                  end else begin
                     pos_in   = pos_ff + POS_W'(1);
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_ESC: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_end_in   = 1'b0;
               out_byte_in  = esc_ff;
               pos_in       = pos_ff + POS_W'(1);
               state_in     = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         crc_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
      end
      len_ff      <= len_in;
      pad_ff      <= pad_in;
      esc_ff      <= esc_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_line_byte = out_byte_ff;
   assign rsp_frame_end = out_end_ff;

endmodule

`default_nettype wire

>>> design/serial_frame_encoder_crc16.sv
// Channel   Ports                                      Direction
// request   req_valid, req_ready, req_data_byte        in
// response  rsp_valid, rsp_ready, rsp_line_byte,       out
//           rsp_frame_end
// control   csr_wr_en, csr_index, csr_wr_data          in
//
// A request that does not close a frame is taken and written to the payload
// store. A closing request starts a frame of PAYLOAD_BYTES + 13 bytes plus
// escapes; each frame byte passes a fetch step (a store read for stored payload
// bytes), then an emit step, and an escaped byte adds a second emit step.
// req_ready is low while a frame is being emitted; a stalled response holds the
// emitter in place. Reset clears the fill count and CRC and returns the control
// registers to their default values.
`default_nettype none

module serial_frame_encoder_crc16
   import sfe_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_data_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [7:0]            rsp_line_byte,
   output logic                       rsp_frame_end,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   hdr_cfg_type      cfg_ff, cfg_in;
   logic             accept;
   logic [CNT_W-1:0] fill_next;
   logic             flush;
   logic             busy;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [7:0]       mem_rd_data;

   assign accept    = req_valid && req_ready;
   assign fill_next = fill_count_ff + CNT_W'(1);
   assign flush     = (fill_next == CNT_W'(PAYLOAD_BYTES)) || (req_data_byte == NEWLINE_BYTE);
   assign req_ready = !busy;

   always_comb begin
      fill_count_in = fill_count_ff;
      if (accept) begin
         fill_count_in = flush ? '0 : fill_next;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MSG_TYPE:  cfg_in.msg_type  = csr_wr_data[7:0];
            CSR_GROUP_ID:  cfg_in.group_id  = csr_wr_data[7:0];
            CSR_DEST_ADDR: cfg_in.dest_addr = csr_wr_data;
            CSR_SRC_ADDR:  cfg_in.src_addr  = csr_wr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff    <= '0;
         cfg_ff.msg_type  <= 8'd10;
         cfg_ff.group_id  <= 8'd67;
         cfg_ff.dest_addr <= 16'd65535;
         cfg_ff.src_addr  <= 16'd65503;
      end else begin
         fill_count_ff <= fill_count_in;
         cfg_ff        <= cfg_in;
      end
   end

   sfe_store #(
      .DEPTH  (PAYLOAD_BYTES),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (fill_count_ff[IDX_W-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sfe_frame #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .CNT_W         (CNT_W),
      .IDX_W         (IDX_W)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .start         (accept && flush),
      .start_len     (fill_next),
      .hdr_cfg       (cfg_ff),
      .busy          (busy),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_byte (rsp_line_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

>>> design/sfe_checker.sv
`default_nettype none

module sfe_checker
   import sfe_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_data_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_line_byte,
   input wire logic       rsp_frame_end
);

   // closing byte of a frame is always the flag
   a_end_is_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_line_byte == FLAG_BYTE)
      else $error("frame end without flag byte");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a newline always closes a frame, so the input must stall next cycle
   a_newline_flush: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data_byte == NEWLINE_BYTE |=> !req_ready)
      else $error("newline did not start a frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_byte)
         && $stable(rsp_frame_end))
      else $error("stalled response changed");

endmodule

bind serial_frame_encoder_crc16 sfe_checker u_sfe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_data_byte (req_data_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_line_byte (rsp_line_byte),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire
